### hdl/vgmp_pkg.sv
// Shared types and constants for the VGM command stream parser.
// No dependencies; used by every module under hdl/.
`default_nettype none

package vgmp_pkg;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NTSC_FRAME_WAIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAL_FRAME_WAIT  = 1'd1;

   localparam logic [15:0] NTSC_FRAME_WAIT_RESET = 16'd735;
   localparam logic [15:0] PAL_FRAME_WAIT_RESET  = 16'd882;

   // Result event kinds
   localparam logic [1:0] EVENT_WAIT       = 2'd0;
   localparam logic [1:0] EVENT_PORT_WRITE = 2'd1;
   localparam logic [1:0] EVENT_FINISHED   = 2'd2;
   localparam logic [1:0] EVENT_BAD_HEADER = 2'd3;

   // Opcodes
   localparam logic [7:0] OP_WAIT_16     = 8'h61;
   localparam logic [7:0] OP_WAIT_NTSC   = 8'h62;
   localparam logic [7:0] OP_WAIT_PAL    = 8'h63;
   localparam logic [7:0] OP_END         = 8'h66;
   localparam logic [7:0] OP_DATA_BLOCK  = 8'h67;
   localparam logic [7:0] OP_PORT_B3     = 8'hB3;
   localparam logic [7:0] OP_PORT_BC     = 8'hBC;
   localparam logic [3:0] OP_SHORT_WAIT  = 4'h7;
   localparam logic [3:0] LOW_NIBBLE     = 4'hF;

   // Header layout
   localparam logic [31:0] HDR_MAGIC_END   = 32'h0000_0004;
   localparam logic [31:0] HDR_OFFSET_LO   = 32'h0000_0034;
   localparam logic [31:0] HDR_OFFSET_HI   = 32'h0000_0037;
   localparam logic [31:0] HDR_LAST_BYTE   = 32'h0000_003F;
   localparam logic [31:0] CMD_START_MIN   = 32'h0000_0040;
   localparam logic [32:0] HDR_OFFSET_BASE = 33'h0_0000_0034;

   // One queue entry: everything one input byte produces
   typedef struct packed {
      logic        has_event;
      logic [1:0]  kind;
      logic [15:0] wait_samples;
      logic [7:0]  port_number;
      logic [7:0]  port_value;
      logic        finish;
   } entry_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h56;
         2'd1:    r = 8'h67;
         2'd2:    r = 8'h6D;
         default: r = 8'h20;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/vgmp_front.sv
// Front end: accepts file bytes, tracks header and command parsing, and
// builds one queue entry per byte that yields results. Uses vgmp_pkg.
`default_nettype none

module vgmp_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_end_of_file,
   input  wire logic                             csr_wr_en,
   input  wire logic [vgmp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [vgmp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             space_avail,
   output      logic                             push,
   output      vgmp_pkg::entry_type              push_entry
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SEEK,
      PH_OPCODE,
      PH_OPERANDS,
      PH_SKIP,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in, work_phase;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] cstart_ff, cstart_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [31:0] ob_ff, ob_in;
   logic [2:0]  idx_ff, idx_in;
   logic [31:0] skip_ff, skip_in;
   logic [15:0] ntsc_ff, pal_ff;

   logic        accept;
   logic [31:0] ob_hdr, ob_blk, skip_dec;
   logic [15:0] ob_pair;
   logic [1:0]  blk_lane;
   logic [32:0] start_sum;
   logic [31:0] start_val;
   vgmp_pkg::entry_type ent;

   assign req_ready = space_avail;
   assign accept    = req_valid && space_avail;

   // header offset bytes land by position; 0x34 is 4-aligned
   assign ob_hdr    = ob_ff | ({24'd0, req_data_byte} << {pos_ff[1:0], 3'b000});
   assign blk_lane  = idx_ff[1:0] - 2'd2;
   assign ob_blk    = ob_ff | ({24'd0, req_data_byte} << {blk_lane, 3'b000});
   assign ob_pair   = ob_ff[15:0] | ({8'd0, req_data_byte} << {idx_ff[0], 3'b000});
   assign skip_dec  = skip_ff - 32'd1;
   assign start_sum = {1'b0, ob_hdr} + vgmp_pkg::HDR_OFFSET_BASE;

   always_comb begin
      if (ob_hdr == 32'd0) begin
         start_val = vgmp_pkg::CMD_START_MIN;
      end else if (start_sum[32]) begin
         start_val = '1;
      end else if (start_sum[31:0] < vgmp_pkg::CMD_START_MIN) begin
         start_val = vgmp_pkg::CMD_START_MIN;
      end else begin
         start_val = start_sum[31:0];
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      cstart_in  = cstart_ff;
      opcode_in  = opcode_ff;
      ob_in      = ob_ff;
      idx_in     = idx_ff;
      skip_in    = skip_ff;
      ent        = '0;
      work_phase = phase_ff;
      if (accept && phase_ff != PH_DONE) begin
         if (pos_ff != '1) begin
            pos_in = pos_ff + 32'd1;
         end
         if (phase_ff == PH_SEEK && pos_ff >= cstart_ff) begin
            work_phase = PH_OPCODE;
         end
         phase_in = work_phase;
         case (work_phase)
            PH_HEADER: begin
               if (pos_ff < vgmp_pkg::HDR_MAGIC_END &&
                   req_data_byte != vgmp_pkg::magic_byte(pos_ff[1:0])) begin
                  ent.has_event = 1'b1;
                  ent.kind      = vgmp_pkg::EVENT_BAD_HEADER;
                  phase_in      = PH_DONE;
               end else begin
                  if (pos_ff >= vgmp_pkg::HDR_OFFSET_LO &&
                      pos_ff <= vgmp_pkg::HDR_OFFSET_HI) begin
                     ob_in = ob_hdr;
                  end
                  if (pos_ff == vgmp_pkg::HDR_OFFSET_HI) begin
                     cstart_in = start_val;
                     ob_in     = '0;
                  end
                  if (pos_ff >= vgmp_pkg::HDR_LAST_BYTE) begin
                     phase_in = PH_SEEK;
                  end else if (req_end_of_file) begin
                     ent.has_event = 1'b1;
                     ent.kind      = vgmp_pkg::EVENT_BAD_HEADER;
                     phase_in      = PH_DONE;
                  end
               end
            end
            PH_OPCODE: begin
               if (req_data_byte == vgmp_pkg::OP_WAIT_16 ||
                   req_data_byte == vgmp_pkg::OP_PORT_B3 ||
                   req_data_byte == vgmp_pkg::OP_PORT_BC ||
                   req_data_byte == vgmp_pkg::OP_DATA_BLOCK) begin
                  opcode_in = req_data_byte;
                  ob_in     = '0;
                  idx_in    = '0;
                  phase_in  = PH_OPERANDS;
               end else if (req_data_byte == vgmp_pkg::OP_WAIT_NTSC) begin
                  ent.has_event    = 1'b1;
                  ent.kind         = vgmp_pkg::EVENT_WAIT;
                  ent.wait_samples = ntsc_ff;
               end else if (req_data_byte == vgmp_pkg::OP_WAIT_PAL) begin
                  ent.has_event    = 1'b1;
                  ent.kind         = vgmp_pkg::EVENT_WAIT;
                  ent.wait_samples = pal_ff;
               end else if (req_data_byte == vgmp_pkg::OP_END) begin
                  ent.has_event = 1'b1;
                  ent.kind      = vgmp_pkg::EVENT_FINISHED;
                  phase_in      = PH_DONE;
               end else if (req_data_byte[7:4] == vgmp_pkg::OP_SHORT_WAIT) begin
                  ent.has_event    = 1'b1;
                  ent.kind         = vgmp_pkg::EVENT_WAIT;
                  ent.wait_samples = {12'd0, req_data_byte[3:0] & vgmp_pkg::LOW_NIBBLE}
                                     + 16'd1;
               end
            end
            PH_OPERANDS: begin
               idx_in = idx_ff + 3'd1;
               if (opcode_ff == vgmp_pkg::OP_DATA_BLOCK) begin
                  if (idx_ff >= 3'd2) begin
                     ob_in = ob_blk;
                  end
                  if (idx_ff >= 3'd5) begin
                     skip_in  = ob_in;
                     phase_in = (ob_in == 32'd0) ? PH_OPCODE : PH_SKIP;
                  end
               end else begin
                  ob_in = {16'd0, ob_pair};
                  if (idx_ff >= 3'd1) begin
                     ent.has_event = 1'b1;
                     if (opcode_ff == vgmp_pkg::OP_WAIT_16) begin
                        ent.kind         = vgmp_pkg::EVENT_WAIT;
                        ent.wait_samples = ob_pair;
                     end else begin
                        ent.kind        = vgmp_pkg::EVENT_PORT_WRITE;
                        ent.port_number = ob_pair[7:0];
                        ent.port_value  = ob_pair[15:8];
                     end
                     phase_in = PH_OPCODE;
                  end
               end
            end
            PH_SKIP: begin
               if (skip_ff != 32'd0) begin
                  skip_in = skip_dec;
               end
               if (skip_in == 32'd0) begin
                  phase_in = PH_OPCODE;
               end
            end
            default: begin
            end
         endcase
         if (req_end_of_file && phase_in != PH_DONE) begin
            ent.finish = 1'b1;
            phase_in   = PH_DONE;
         end
      end
   end

   assign push       = accept && (ent.has_event || ent.finish);
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         cstart_ff <= vgmp_pkg::CMD_START_MIN;
         opcode_ff <= '0;
         ob_ff     <= '0;
         idx_ff    <= '0;
         skip_ff   <= '0;
         ntsc_ff   <= vgmp_pkg::NTSC_FRAME_WAIT_RESET;
         pal_ff    <= vgmp_pkg::PAL_FRAME_WAIT_RESET;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         cstart_ff <= cstart_in;
         opcode_ff <= opcode_in;
         ob_ff     <= ob_in;
         idx_ff    <= idx_in;
         skip_ff   <= skip_in;
         if (csr_wr_en && csr_index == vgmp_pkg::CSR_NTSC_FRAME_WAIT) begin
            ntsc_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == vgmp_pkg::CSR_PAL_FRAME_WAIT) begin
            pal_ff <= csr_wdata;
         end
      end
   end

   // once finished or failed, nothing more reaches the queue
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> !push)
      else $error("entry pushed after end of stream");

endmodule

`default_nettype wire

### hdl/vgmp_queue.sv
// Short FIFO of parsed entries between front and back end.
// Register based, combinational head read. Uses vgmp_pkg.
`default_nettype none

module vgmp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire vgmp_pkg::entry_type push_entry,
   output      logic                space_avail,
   input  wire logic                pop,
   output      logic                head_valid,
   output      vgmp_pkg::entry_type head_entry
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   vgmp_pkg::entry_type slots_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign space_avail = count_ff != FULL_COUNT;
   assign head_valid  = count_ff != '0;
   assign head_entry  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> space_avail)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

### hdl/vgmp_back.sv
// Back end: turns queue entries into result transfers, one or two per
// entry, through a registered output stage. Uses vgmp_pkg.
`default_nettype none

module vgmp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire vgmp_pkg::entry_type head_entry,
   output      logic                pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [1:0]          rsp_event_kind,
   output      logic [15:0]         rsp_wait_samples,
   output      logic [7:0]          rsp_port_number,
   output      logic [7:0]          rsp_port_value,
   output      logic                rsp_last_of_run
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic        second_ff, second_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] wait_ff, wait_in;
   logic [7:0]  port_ff, port_in;
   logic [7:0]  value_ff, value_in;
   logic        last_ff, last_in;
   logic        load;

   assign load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pop          = 1'b0;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = vgmp_pkg::EVENT_FINISHED;
      wait_in      = '0;
      port_in      = '0;
      value_in     = '0;
      last_in      = 1'b1;
      if (load && head_valid) begin
         rsp_valid_in = 1'b1;
         if (head_entry.has_event && !second_ff) begin
            kind_in  = head_entry.kind;
            wait_in  = head_entry.wait_samples;
            port_in  = head_entry.port_number;
            value_in = head_entry.port_value;
            last_in  = !head_entry.finish;
            // finish still owed: keep the entry at the head
            if (head_entry.finish) begin
               second_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            pop       = 1'b1;
            second_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         kind_ff  <= kind_in;
         wait_ff  <= wait_in;
         port_ff  <= port_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_wait_samples = wait_ff;
   assign rsp_port_number  = port_ff;
   assign rsp_port_value   = value_ff;
   assign rsp_last_of_run  = last_ff;

   a_second_held: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> head_valid && head_entry.has_event && head_entry.finish)
      else $error("pending finish lost its queue entry");

endmodule

`default_nettype wire

### hdl/vgm_command_stream_parser_core.sv
// Top level of the VGM command stream parser: front end, entry queue,
// back end. Uses vgmp_pkg, vgmp_front, vgmp_queue, vgmp_back.
//
//   channel | direction | handshake               | payload
//   req_    | in        | req_valid / req_ready   | data_byte, end_of_file
//   rsp_    | out       | rsp_valid / rsp_ready   | event_kind, wait_samples,
//           |           |                         | port_number, port_value, last_of_run
//   csr_    | in        | csr_wr_en (no wait)     | csr_index, csr_wdata
//
// One byte is taken per cycle while the queue has room; its first result is
// presented after it passes the queue and then the output register. A byte
// giving an event plus end of stream yields two result transfers, sent one
// after the other from the single output register of the back end.
// The queue (QUEUE_DEPTH entries) lets bytes keep flowing under output stall.
// Synchronous reset puts the parser back at the file start, with frame waits
// of 735 and 882 samples; no clearing pass is needed.
`default_nettype none

module vgm_command_stream_parser_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_end_of_file,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [1:0]                       rsp_event_kind,
   output      logic [15:0]                      rsp_wait_samples,
   output      logic [7:0]                       rsp_port_number,
   output      logic [7:0]                       rsp_port_value,
   output      logic                             rsp_last_of_run,
   input  wire logic                             csr_wr_en,
   input  wire logic [vgmp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [vgmp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                space_avail;
   logic                push;
   logic                pop;
   logic                head_valid;
   vgmp_pkg::entry_type push_entry;
   vgmp_pkg::entry_type head_entry;

   vgmp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .space_avail     (space_avail),
      .push            (push),
      .push_entry      (push_entry)
   );

   vgmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .space_avail (space_avail),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_entry  (head_entry)
   );

   vgmp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_wait_samples (rsp_wait_samples),
      .rsp_port_number  (rsp_port_number),
      .rsp_port_value   (rsp_port_value),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire
